### rtl/rabh_pkg.sv
// shared constants and payload types for the row argmax bucket histogram
package rabh_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PosWidth   = 7;
  localparam int unsigned IndexWidth = 5;
  localparam int unsigned CountWidth = 32;

  localparam logic [PosWidth-1:0]   PosMax   = 7'd127;
  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic {
    OP_COLUMN = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [ValueWidth-1:0] column_value;
    logic                  last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [IndexWidth-1:0] bucket_index;
    logic [CountWidth-1:0] bucket_count;
    logic                  overflow;
  } out_item_t;

endpackage

### rtl/rabh_if.sv
// valid/ready channel interfaces for input and result transactions
interface rabh_in_if;
  logic               valid;
  logic               ready;
  rabh_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rabh_out_if;
  logic                valid;
  logic                ready;
  rabh_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/rabh_counter_bank.sv
// bucket counter memory with per-entry valid bits, forwarding and saturating increment
module rabh_counter_bank #(
  parameter int unsigned NUM_BUCKETS = 32,
  localparam int unsigned IW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              clear_i,
  input  logic                              rd_en_i,
  input  logic [IW-1:0]                     rd_idx_i,
  input  logic                              upd_i,
  input  logic [IW-1:0]                     upd_idx_i,
  output logic [rabh_pkg::CountWidth-1:0]   count_o
);

  logic [rabh_pkg::CountWidth-1:0] mem [NUM_BUCKETS];
  logic [rabh_pkg::CountWidth-1:0] rd_q;
  logic [NUM_BUCKETS-1:0]          vld_q, vld_d;
  logic                            fwd_q, fwd_d;
  logic [IW-1:0]                   fwd_idx_q;
  logic [rabh_pkg::CountWidth-1:0] fwd_cnt_q;
  logic [rabh_pkg::CountWidth-1:0] old_cnt, new_cnt;
  logic                            wr;

  assign wr = en_i && upd_i;

  always_comb begin
    // last cycle's write is not yet visible in the registered read data
    if (fwd_q && (fwd_idx_q == upd_idx_i)) begin
      old_cnt = fwd_cnt_q;
    end else if (vld_q[upd_idx_i]) begin
      old_cnt = rd_q;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt == rabh_pkg::CountMax) ? old_cnt : old_cnt + 1'b1;
  end

  assign count_o = new_cnt;

  always_comb begin
    vld_d = vld_q;
    if (wr) begin
      vld_d[upd_idx_i] = 1'b1;
    end
    // clear belongs to a later transaction than the pending update
    if (en_i && clear_i) begin
      vld_d = '0;
    end
    fwd_d = en_i ? wr : fwd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[upd_idx_i] <= new_cnt;
      fwd_idx_q      <= upd_idx_i;
      fwd_cnt_q      <= new_cnt;
    end
    if (en_i && rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

endmodule

### rtl/row_argmax_bucket_histogram_core.sv
// top level: row argmax tracking and bucket histogram output
//
//   channel  dir  payload                                    accepted when
//   in_i     in   opcode, column_value, last_in_row          valid && ready
//   out_o    out  bucket_index, bucket_count, overflow       valid && ready
//
// one transaction per cycle while the input is not stalled; a result leaves
// through the input register, counter read and result register after its row's last column.
// the counter memory read port sets the middle stage. reset clears row state
// and the counter valid bits at once. the input stalls only when a row result
// is waiting behind a result that the sink has not taken.
module row_argmax_bucket_histogram_core #(
  parameter int unsigned NUM_BUCKETS  = 32,
  parameter int unsigned LEAD_COLUMNS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rabh_in_if.sink    in_i,
  rabh_out_if.source out_o
);

  localparam int unsigned IW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned PW = rabh_pkg::PosWidth;
  localparam int unsigned VW = rabh_pkg::ValueWidth;

  logic en;

  // input register
  logic               a_vld_q;
  rabh_pkg::in_item_t a_q;

  // row state
  logic [VW-1:0] max_q, max_d;
  logic [IW-1:0] best_q, best_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          ovf_q, ovf_d;

  // counter stage
  logic          b_res_q, b_ovf_q;
  logic [IW-1:0] b_idx_q;

  // result register
  logic                    out_vld_q;
  rabh_pkg::out_item_t     out_q;
  logic [rabh_pkg::CountWidth-1:0] count;

  logic          a_col, a_clr, a_res, is_feat, excess, wins, nan;
  logic [PW-1:0] feat;
  logic [IW-1:0] fin_idx;
  logic          fin_ovf;

  assign en       = !(b_res_q && out_vld_q && !out_o.ready);
  assign in_i.ready = en;

  always_comb begin
    a_col   = a_vld_q && (a_q.opcode == rabh_pkg::OP_COLUMN);
    a_clr   = a_vld_q && (a_q.opcode == rabh_pkg::OP_CLEAR);
    a_res   = a_col && a_q.last_in_row;
    is_feat = pos_q >= PW'(LEAD_COLUMNS);
    feat    = pos_q - PW'(LEAD_COLUMNS);
    excess  = (pos_q >= rabh_pkg::PosMax) || ({1'b0, feat} >= (PW + 1)'(NUM_BUCKETS));
    nan     = (a_q.column_value[30:23] == 8'hff) && (a_q.column_value[22:0] != '0);
    // running max is never negative, so magnitude order decides
    wins    = !a_q.column_value[31] && !nan && (a_q.column_value[30:0] > max_q[30:0]);

    max_d = max_q;
    best_d = best_q;
    ovf_d = ovf_q;
    if (is_feat) begin
      if (excess) begin
        ovf_d = 1'b1;
      end else if (wins) begin
        max_d  = a_q.column_value;
        best_d = IW'(feat);
      end
    end
    pos_d   = (pos_q == rabh_pkg::PosMax) ? pos_q : pos_q + 1'b1;
    fin_idx = best_d;
    fin_ovf = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      max_q     <= '0;
      best_q    <= '0;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
      b_res_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en) begin
        a_vld_q <= in_i.valid;
        b_res_q <= a_res;
        if (a_col) begin
          if (a_q.last_in_row) begin
            max_q  <= '0;
            best_q <= '0;
            pos_q  <= '0;
            ovf_q  <= 1'b0;
          end else begin
            max_q  <= max_d;
            best_q <= best_d;
            pos_q  <= pos_d;
            ovf_q  <= ovf_d;
          end
        end
      end
      if (en && b_res_q) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= in_i.data;
      b_idx_q <= fin_idx;
      b_ovf_q <= fin_ovf;
    end
    if (en && b_res_q) begin
      out_q.bucket_index <= 5'(b_idx_q);
      out_q.bucket_count <= count;
      out_q.overflow     <= b_ovf_q;
    end
  end

  rabh_counter_bank #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .clear_i  (a_clr),
    .rd_en_i  (a_res),
    .rd_idx_i (fin_idx),
    .upd_i    (b_res_q),
    .upd_idx_i(b_idx_q),
    .count_o  (count)
  );

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

### tb/row_argmax_bucket_histogram_core_tb.sv
// testbench for the row argmax bucket histogram core
module row_argmax_bucket_histogram_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBuckets  = 32;
  localparam int unsigned LeadColumns = 4;

  logic clk_i;
  logic rst_ni;

  rabh_in_if  in_if ();
  rabh_out_if out_if ();

  row_argmax_bucket_histogram_core #(
    .NUM_BUCKETS (NumBuckets),
    .LEAD_COLUMNS(LeadColumns)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // predictor state
  logic [31:0] row_max;
  logic [31:0] row_best;
  logic [6:0]  row_pos;
  logic        row_ovf;
  logic [31:0] bucket_cnt [NumBuckets];

  rabh_pkg::out_item_t expected_q[$];
  int                  error_count;
  int                  send_idle_pct;
  int                  sink_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ieee single greater-than on raw bit patterns, nan never greater
  function automatic bit float_gt(logic [31:0] a, logic [31:0] b);
    bit a_nan;
    bit b_nan;
    bit a_zero;
    bit b_zero;
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 0);
    a_zero = (a[30:0] == 0);
    b_zero = (b[30:0] == 0);
    if (a_nan || b_nan) return 1'b0;
    if (a_zero && b_zero) return 1'b0;
    if (a[31] != b[31]) return b[31];
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  function automatic void reset_row();
    row_max  = '0;
    row_best = '0;
    row_pos  = '0;
    row_ovf  = 1'b0;
  endfunction

  function automatic void predict_histogram(rabh_pkg::in_item_t it);
    int unsigned         feat;
    int unsigned         idx;
    rabh_pkg::out_item_t res;
    if (it.opcode == rabh_pkg::OP_CLEAR) begin
      foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
      return;
    end
    if (row_pos >= LeadColumns) begin
      feat = row_pos - LeadColumns;
      if (row_pos >= rabh_pkg::PosMax || feat >= NumBuckets) row_ovf = 1'b1;
      else if (float_gt(it.column_value, row_max)) begin
        row_max  = it.column_value;
        row_best = feat;
      end
    end
    if (row_pos < rabh_pkg::PosMax) row_pos = row_pos + 1'b1;
    if (!it.last_in_row) return;
    idx = (row_best >= NumBuckets) ? 0 : row_best;
    if (bucket_cnt[idx] != rabh_pkg::CountMax) bucket_cnt[idx] = bucket_cnt[idx] + 1;
    res.bucket_index = idx[4:0];
    res.bucket_count = bucket_cnt[idx];
    res.overflow     = row_ovf;
    expected_q.push_back(res);
    reset_row();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // result checker and sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_if.data.bucket_count, '0);
        end else begin
          rabh_pkg::out_item_t want;
          want = expected_q.pop_front();
          if (out_if.data.bucket_index != want.bucket_index)
            report_mismatch("bucket_index", 32'(out_if.data.bucket_index),
                            32'(want.bucket_index));
          if (out_if.data.bucket_count != want.bucket_count)
            report_mismatch("bucket_count", out_if.data.bucket_count, want.bucket_count);
          if (out_if.data.overflow != want.overflow)
            report_mismatch("overflow", 32'(out_if.data.overflow), 32'(want.overflow));
        end
      end
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_item(rabh_pkg::opcode_e op, logic [31:0] value, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.data.opcode       <= op;
    in_if.data.column_value <= value;
    in_if.data.last_in_row  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_histogram('{opcode: op, column_value: value, last_in_row: last});
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    go_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(9))
      0: return 32'h7fc0_0000 | $urandom_range(32'h3f_ffff);
      1: return 32'h7f80_0000;
      2: return 32'hff80_0000;
      3: return {1'($urandom_range(1)), 31'h0};
      4: return {1'b1, 31'($urandom())};
      5: return {1'b0, 8'h00, 23'($urandom())};
      6: return $urandom();
      default: return {1'b0, 8'($urandom_range(120, 135)), 23'($urandom())};
    endcase
  endfunction

  task automatic send_row(int unsigned n_cols, bit noisy);
    for (int unsigned c = 0; c < n_cols; c++) begin
      if (noisy && $urandom_range(40) == 0)
        send_item(rabh_pkg::OP_CLEAR, $urandom(), 1'($urandom()));
      send_item(rabh_pkg::OP_COLUMN, rand_float(), c == n_cols - 1);
    end
  endtask

  task automatic test_directed();
    send_row(1, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h0, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h0, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h0, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'hffff_ffff, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h3f80_0000, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h3f80_0000, 0);
    send_item(rabh_pkg::OP_CLEAR, 32'hffff_ffff, 1);
    send_item(rabh_pkg::OP_COLUMN, 32'h7f80_0000, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h7fff_ffff, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h8000_0000, 1);
    send_item(rabh_pkg::OP_COLUMN, 32'h0, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h0, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h0, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h0, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'hbf80_0000, 1);
    send_item(rabh_pkg::OP_CLEAR, 32'h0, 0);
    send_item(rabh_pkg::OP_COLUMN, 32'h0000_0001, 1);
    wait_drained();
  endtask

  task automatic test_long_rows();
    // rows past the bucket count and past the position saturation
    send_row(LeadColumns + NumBuckets + 1, 0);
    send_row(140, 0);
    wait_drained();
  endtask

  task automatic test_random(int unsigned n_items, int idle, int stall);
    int unsigned sent;
    send_idle_pct  = idle;
    sink_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      int unsigned n;
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 5) :
          $urandom_range(LeadColumns + 1, LeadColumns + NumBuckets + 2);
      send_row(n, 1);
      sent += n;
      if ($urandom_range(30) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    error_count    = 0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    rst_ni         = 1'b0;
    reset_row();
    foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_rows();
    test_random(300, 0, 0);
    test_random(450, 85, 0);
    test_random(450, 0, 85);
    test_random(450, 9, 9);
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("row_argmax_bucket_histogram_core test passed");
    end else begin
      $display("row_argmax_bucket_histogram_core test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("row_argmax_bucket_histogram_core test failed");
    $finish;
  end

endmodule

### files.f
rtl/rabh_pkg.sv
rtl/rabh_if.sv
rtl/rabh_counter_bank.sv
rtl/row_argmax_bucket_histogram_core.sv
tb/row_argmax_bucket_histogram_core_tb.sv
